### rtl/bli_pkg.sv
package bli_pkg;

  localparam int MAX_POINTS_DEF = 8;
  localparam int VALUE_BITS_DEF = 32;
  localparam int COUNT_BITS = 4;
  localparam int FUNC_BITS = 2;
  localparam int SLOT_BITS = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [FUNC_BITS-1:0] FUNC_ROW_WR = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_COL_WR = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_TAB_WR = 2'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_QUERY = 2'd3;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [SLOT_BITS-1:0] slot;
  } cmd_t;

endpackage

### rtl/bilinear_lut_interpolator_unit.sv
// channel  | handshake            | payload
// in       | in_valid/in_ready    | func slot write_value query_x query_y
// out      | out_valid/out_ready  | result_value segment_error
// cfg      | cfg_we               | cfg_index cfg_data
// a transfer enters the two-entry queue and is registered there before it reaches the back part
// writes are done in the back part when it takes them; a query goes through search,
// table reads and output, with interpolation steps between (three for a full table)
// a bad segment or an extreme query ends its step without the division
// rst is synchronous and clears control state and the counts to one
// writes go on while a result waits; a query's result holds until out is free, out holds until out_ready
module bilinear_lut_interpolator_unit #(
  parameter int MAX_POINTS = bli_pkg::MAX_POINTS_DEF,
  parameter int VALUE_BITS = bli_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [bli_pkg::COUNT_BITS-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [bli_pkg::FUNC_BITS-1:0] func,
  input  logic [bli_pkg::SLOT_BITS-1:0] slot,
  input  logic [VALUE_BITS-1:0] write_value,
  input  logic [VALUE_BITS-1:0] query_x,
  input  logic [VALUE_BITS-1:0] query_y,
  output logic out_valid,
  input  logic out_ready,
  output logic [VALUE_BITS-1:0] result_value,
  output logic segment_error
);
  logic [bli_pkg::COUNT_BITS-1:0] row_count, column_count;
  bli_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;
  logic [VALUE_BITS-1:0] q_wv, q_qx, q_qy;

  assign in_cmd.func = func;
  assign in_cmd.slot = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= bli_pkg::COUNT_BITS'(1);
      column_count <= bli_pkg::COUNT_BITS'(1);
    end else if (cfg_we) begin
      if (cfg_index == bli_pkg::CFG_ROW_COUNT) row_count <= cfg_data;
      else column_count <= cfg_data;
    end
  end

  bli_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_ready, .in_cmd,
    .in_wv(write_value), .in_qx(query_x), .in_qy(query_y),
    .q_valid, .q_ready, .q_cmd, .q_wv, .q_qx, .q_qy
  );

  bli_back #(.MAX_POINTS(MAX_POINTS), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst, .row_count, .column_count,
    .q_valid, .q_ready, .q_cmd, .q_wv, .q_qx, .q_qy,
    .out_valid, .out_ready, .result_value, .segment_error
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("result changed while stalled");
  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("queue full but empty at back");
endmodule

### rtl/bli_front.sv
module bli_front #(
  parameter int VALUE_BITS = bli_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  bli_pkg::cmd_t in_cmd,
  input  logic [VALUE_BITS-1:0] in_wv,
  input  logic [VALUE_BITS-1:0] in_qx,
  input  logic [VALUE_BITS-1:0] in_qy,
  output logic q_valid,
  input  logic q_ready,
  output bli_pkg::cmd_t q_cmd,
  output logic [VALUE_BITS-1:0] q_wv,
  output logic [VALUE_BITS-1:0] q_qx,
  output logic [VALUE_BITS-1:0] q_qy
);
  localparam int PW = $bits(bli_pkg::cmd_t) + 3 * VALUE_BITS;
  logic [PW-1:0] fifo [bli_pkg::QUEUE_DEPTH];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  assign in_ready = (cnt != 2'(bli_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt != 2'd0);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign {q_cmd, q_wv, q_qx, q_qy} = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= {in_cmd, in_wv, in_qx, in_qy};
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### rtl/bli_back.sv
module bli_back #(
  parameter int MAX_POINTS = bli_pkg::MAX_POINTS_DEF,
  parameter int VALUE_BITS = bli_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic [bli_pkg::COUNT_BITS-1:0] row_count,
  input  logic [bli_pkg::COUNT_BITS-1:0] column_count,
  input  logic q_valid,
  output logic q_ready,
  input  bli_pkg::cmd_t q_cmd,
  input  logic [VALUE_BITS-1:0] q_wv,
  input  logic [VALUE_BITS-1:0] q_qx,
  input  logic [VALUE_BITS-1:0] q_qy,
  output logic out_valid,
  input  logic out_ready,
  output logic [VALUE_BITS-1:0] result_value,
  output logic segment_error
);
  localparam int PB = $clog2(MAX_POINTS);
  localparam int TD = MAX_POINTS * MAX_POINTS;
  localparam int TB = $clog2(TD);
  localparam int W = VALUE_BITS;
  localparam int PRODW = 2 * W + 2;
  localparam int CW = $clog2(PRODW + 1);
  localparam int NB = PB + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_RDP = 4'd2;
  localparam logic [3:0] S_RDT = 4'd3;
  localparam logic [3:0] S_SET = 4'd4;
  localparam logic [3:0] S_MUL = 4'd5;
  localparam logic [3:0] S_DIV = 4'd6;
  localparam logic [3:0] S_FIN = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;
  localparam logic [3:0] S_RND = 4'd9;
  localparam logic [3:0] S_SAT = 4'd10;

  localparam logic [1:0] MODE_ONE = 2'd0;
  localparam logic [1:0] MODE_COL = 2'd1;
  localparam logic [1:0] MODE_ROW = 2'd2;
  localparam logic [1:0] MODE_FULL = 2'd3;

  logic signed [W-1:0] rowp [MAX_POINTS];
  logic signed [W-1:0] colp [MAX_POINTS];
  logic signed [W-1:0] tab [TD];

  logic [3:0] state;
  logic [NB-1:0] nr, nc;
  logic signed [W-1:0] x, y;
  logic [NB-1:0] ri, ci, scan;
  logic rfound, cfound;
  logic [1:0] mode;
  logic [1:0] step;
  logic [1:0] tsel;
  logic [TB-1:0] taddr;
  logic signed [W-1:0] tdata;
  logic signed [W-1:0] t00, t01, t10, t11, v0;
  logic signed [W-1:0] rx1, rx2, cx1, cx2;
  logic signed [W-1:0] ix, ix1, ix2, iy1, iy2;
  logic signed [W-1:0] acc;
  logic err, neg;
  logic [W:0] ua, ub, ud;
  logic [PRODW-1:0] prod;
  logic [W+1:0] rem;
  logic [PRODW-1:0] quo;
  logic [CW-1:0] bitc;
  logic sh;

  function automatic logic [NB-1:0] eff(input logic [bli_pkg::COUNT_BITS-1:0] c);
    logic [NB-1:0] r;
    if (c == '0) r = NB'(1);
    else if (32'(c) > MAX_POINTS) r = NB'(MAX_POINTS);
    else r = NB'(c);
    return r;
  endfunction

  function automatic logic [NB-1:0] clampi(input logic [NB-1:0] i, input logic [NB-1:0] n);
    logic [NB-1:0] r;
    r = i;
    if (r > n - NB'(1)) r = n - NB'(1);
    if (r < NB'(1)) r = NB'(1);
    return r;
  endfunction

  assign q_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      case (q_cmd.func)
        bli_pkg::FUNC_ROW_WR:
          if (32'(q_cmd.slot) < MAX_POINTS) rowp[q_cmd.slot[PB-1:0]] <= q_wv;
        bli_pkg::FUNC_COL_WR:
          if (32'(q_cmd.slot) < MAX_POINTS) colp[q_cmd.slot[PB-1:0]] <= q_wv;
        bli_pkg::FUNC_TAB_WR:
          if (32'(q_cmd.slot) < TD) tab[q_cmd.slot[TB-1:0]] <= q_wv;
        default: ;
      endcase
    end
    tdata <= tab[taddr];
  end

  logic [NB-1:0] r_eff, c_eff;
  always_comb begin
    r_eff = clampi(rfound ? ri : nr, nr);
    c_eff = clampi(cfound ? ci : nc, nc);
  end

  logic [2*NB-1:0] b0, b1;
  always_comb begin
    b0 = (2*NB)'(r_eff - NB'(1)) * (2*NB)'(nc);
    b1 = (2*NB)'(r_eff) * (2*NB)'(nc);
    case (mode)
      MODE_ONE: taddr = '0;
      MODE_COL: taddr = TB'(tsel[0] ? c_eff : c_eff - NB'(1));
      MODE_ROW: taddr = TB'(tsel[0] ? r_eff : r_eff - NB'(1));
      default: begin
        case (tsel)
          2'd0: taddr = TB'(b0 + (2*NB)'(c_eff) - (2*NB)'(1));
          2'd1: taddr = TB'(b1 + (2*NB)'(c_eff) - (2*NB)'(1));
          2'd2: taddr = TB'(b0 + (2*NB)'(c_eff));
          default: taddr = TB'(b1 + (2*NB)'(c_eff));
        endcase
      end
    endcase
  end

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    ua = (ix >= ix1) ? (W+1)'($signed({ix[W-1], ix}) - $signed({ix1[W-1], ix1}))
                     : (W+1)'($signed({ix1[W-1], ix1}) - $signed({ix[W-1], ix}));
    ub = (iy2 >= iy1) ? (W+1)'($signed({iy2[W-1], iy2}) - $signed({iy1[W-1], iy1}))
                      : (W+1)'($signed({iy1[W-1], iy1}) - $signed({iy2[W-1], iy2}));
    ud = (W+1)'($signed({ix2[W-1], ix2}) - $signed({ix1[W-1], ix1}));
  end

  logic [W+1:0] rem_sh;
  logic signed [W+1:0] sum;
  always_comb begin
    rem_sh = {rem[W:0], prod[PRODW-1]};
    sh = (rem_sh >= {1'b0, ud});
    sum = neg ? ($signed({{2{iy1[W-1]}}, iy1}) - $signed({2'b00, quo[W-1:0]}))
              : ($signed({{2{iy1[W-1]}}, iy1}) + $signed({2'b00, quo[W-1:0]}));
  end

  logic signed [W-1:0] satv;
  always_comb begin
    if (|quo[PRODW-1:W]) satv = neg ? VMIN : VMAX;
    else if (sum > $signed({{2{VMAX[W-1]}}, VMAX})) satv = VMAX;
    else if (sum < $signed({{2{VMIN[W-1]}}, VMIN})) satv = VMIN;
    else satv = sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (q_valid && q_ready && q_cmd.func == bli_pkg::FUNC_QUERY) begin
          nr <= eff(row_count);
          nc <= eff(column_count);
          x <= q_qx;
          y <= q_qy;
          scan <= '0;
          rfound <= 1'b0;
          cfound <= 1'b0;
          err <= 1'b0;
          state <= S_SRCH;
        end
        S_SRCH: begin
          if (!rfound && scan < nr && rowp[scan[PB-1:0]] >= x) begin
            rfound <= 1'b1;
            ri <= scan;
          end
          if (!cfound && scan < nc && colp[scan[PB-1:0]] >= y) begin
            cfound <= 1'b1;
            ci <= scan;
          end
          scan <= scan + NB'(1);
          if (scan == NB'(MAX_POINTS - 1)) state <= S_RDP;
        end
        S_RDP: begin
          rx1 <= rowp[PB'(r_eff - NB'(1))];
          rx2 <= rowp[PB'(r_eff)];
          cx1 <= colp[PB'(c_eff - NB'(1))];
          cx2 <= colp[PB'(c_eff)];
          if (nr == NB'(1) && nc == NB'(1)) mode <= MODE_ONE;
          else if (nr == NB'(1)) mode <= MODE_COL;
          else if (nc == NB'(1)) mode <= MODE_ROW;
          else mode <= MODE_FULL;
          tsel <= 2'd0;
          state <= S_RDT;
        end
        S_RDT: begin
          tsel <= tsel + 2'd1;
          case (tsel)
            2'd1: t00 <= tdata;
            2'd2: t01 <= tdata;
            2'd3: t10 <= tdata;
            default: ;
          endcase
          if (tsel == 2'd3) begin
            step <= 2'd0;
            state <= S_SET;
          end
        end
        S_SET: begin
          if (mode == MODE_ONE) begin
            acc <= t00;
            state <= S_OUT;
          end else begin
            if (step == 2'd0) t11 <= tdata;
            if (mode == MODE_COL) begin
              ix <= y; ix1 <= cx1; ix2 <= cx2; iy1 <= t00; iy2 <= t01;
            end else if (mode == MODE_ROW) begin
              ix <= x; ix1 <= rx1; ix2 <= rx2; iy1 <= t00; iy2 <= t01;
            end else if (step == 2'd0) begin
              ix <= x; ix1 <= rx1; ix2 <= rx2; iy1 <= t00; iy2 <= t01;
            end else if (step == 2'd1) begin
              ix <= x; ix1 <= rx1; ix2 <= rx2; iy1 <= t10; iy2 <= t11;
            end else begin
              ix <= y; ix1 <= cx1; ix2 <= cx2; iy1 <= v0; iy2 <= acc;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (ix1 >= ix2) begin
            err <= 1'b1;
            acc <= iy1;
            state <= S_FIN;
          end else if (ix == VMAX || ix == VMIN) begin
            acc <= ix;
            state <= S_FIN;
          end else begin
            neg <= (ix < ix1) ^ (iy2 < iy1);
            prod <= PRODW'(ua) * PRODW'(ub);
            rem <= '0;
            quo <= '0;
            bitc <= CW'(PRODW);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= sh ? rem_sh - {1'b0, ud} : rem_sh;
          quo <= {quo[PRODW-2:0], sh};
          prod <= {prod[PRODW-2:0], 1'b0};
          bitc <= bitc - CW'(1);
          if (bitc == CW'(1)) state <= S_RND;
        end
        S_RND: begin
          if ((rem << 1) >= {1'b0, ud}) quo <= quo + PRODW'(1);
          state <= S_SAT;
        end
        S_SAT: begin
          acc <= satv;
          state <= S_FIN;
        end
        S_FIN: begin
          if (mode == MODE_FULL && step == 2'd0) begin
            v0 <= acc;
            step <= 2'd1;
            state <= S_SET;
          end else if (mode == MODE_FULL && step == 2'd1) begin
            step <= 2'd2;
            state <= S_SET;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: if (!out_valid) begin
          result_value <= acc;
          segment_error <= err;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### test/bli_result_checker.sv
`timescale 1ns / 100ps

module bli_result_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [bli_pkg::COUNT_BITS-1:0] cfg_data,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [bli_pkg::FUNC_BITS-1:0] func,
  input  logic [bli_pkg::SLOT_BITS-1:0] slot,
  input  logic [31:0] write_value,
  input  logic [31:0] query_x,
  input  logic [31:0] query_y,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [31:0] result_value,
  input  logic segment_error,
  output int fails,
  output int pending
);
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam logic [127:0] QUOT_CAP = 128'd1 << 62;

  typedef struct {
    logic [31:0] value;
    logic err;
  } interp_result_t;

  logic [31:0] row_pts [8];
  logic [31:0] col_pts [8];
  logic [31:0] tab_vals [64];
  logic [3:0] row_cnt;
  logic [3:0] col_cnt;
  interp_result_t expected_q [$];

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic int eff(logic [3:0] c);
    if (c < 1) return 1;
    if (c > 8) return 8;
    return int'(c);
  endfunction

  function automatic longint lerp(longint x, longint x1, longint x2, longint y1,
                                  longint y2, inout bit err);
    logic [63:0] a, b, d;
    logic [127:0] p, q, r;
    bit neg;
    longint res;
    neg = 0;
    if (x1 >= x2) begin
      err = 1;
      return y1;
    end
    if (x == VMAX || x == VMIN) return x;
    if (x >= x1) a = x - x1; else begin a = x1 - x; neg = !neg; end
    if (y2 >= y1) b = y2 - y1; else begin b = y1 - y2; neg = !neg; end
    d = x2 - x1;
    p = {64'd0, a} * {64'd0, b};
    q = p / {64'd0, d};
    r = p % {64'd0, d};
    if (q >= QUOT_CAP) q = QUOT_CAP;
    else if (r >= {64'd0, d} - r) q = q + 1;
    res = neg ? y1 - longint'(q[63:0]) : y1 + longint'(q[63:0]);
    if (res > VMAX) res = VMAX;
    if (res < VMIN) res = VMIN;
    return res;
  endfunction

  function automatic int upper_index(bit on_cols, int n, longint q);
    int idx;
    idx = n;
    for (int i = n; i > 0; i--)
      if (sx(on_cols ? col_pts[i-1] : row_pts[i-1]) >= q) idx = i - 1;
    if (idx > n - 1) idx = n - 1;
    if (idx < 1) idx = 1;
    return idx;
  endfunction

  function automatic interp_result_t predict_query(logic [31:0] qx, logic [31:0] qy);
    interp_result_t o;
    int nr, nc, r, c, b0, b1;
    longint x, y, res, v0, v1;
    bit err;
    err = 0;
    nr = eff(row_cnt);
    nc = eff(col_cnt);
    x = sx(qx);
    y = sx(qy);
    if (nr == 1 && nc == 1) begin
      res = sx(tab_vals[0]);
    end else if (nr == 1) begin
      c = upper_index(1, nc, y);
      res = lerp(y, sx(col_pts[c-1]), sx(col_pts[c]), sx(tab_vals[c-1]),
                 sx(tab_vals[c]), err);
    end else if (nc == 1) begin
      r = upper_index(0, nr, x);
      res = lerp(x, sx(row_pts[r-1]), sx(row_pts[r]), sx(tab_vals[r-1]),
                 sx(tab_vals[r]), err);
    end else begin
      r = upper_index(0, nr, x);
      c = upper_index(1, nc, y);
      b0 = (r - 1) * nc;
      b1 = r * nc;
      v0 = lerp(x, sx(row_pts[r-1]), sx(row_pts[r]), sx(tab_vals[b0+c-1]),
                sx(tab_vals[b1+c-1]), err);
      v1 = lerp(x, sx(row_pts[r-1]), sx(row_pts[r]), sx(tab_vals[b0+c]),
                sx(tab_vals[b1+c]), err);
      res = lerp(y, sx(col_pts[c-1]), sx(col_pts[c]), v0, v1, err);
    end
    o.value = res[31:0];
    o.err = err;
    return o;
  endfunction

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    interp_result_t e;
    if (rst) begin
      row_cnt <= 4'd1;
      col_cnt <= 4'd1;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == bli_pkg::CFG_ROW_COUNT) row_cnt <= cfg_data;
        else col_cnt <= cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (fails < 10) $display("unexpected result transfer: %h err %b",
                                   result_value, segment_error);
          fails <= fails + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.value !== result_value || e.err !== segment_error) begin
            if (fails < 10)
              $display("mismatch: expected %h err %b, got %h err %b",
                       e.value, e.err, result_value, segment_error);
            fails <= fails + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (func)
          bli_pkg::FUNC_ROW_WR: if (slot < 8) row_pts[slot[2:0]] = write_value;
          bli_pkg::FUNC_COL_WR: if (slot < 8) col_pts[slot[2:0]] = write_value;
          bli_pkg::FUNC_TAB_WR: tab_vals[slot] = write_value;
          bli_pkg::FUNC_QUERY: expected_q.push_back(predict_query(query_x, query_y));
          default: ;
        endcase
      end
      pending <= expected_q.size();
    end
  end

endmodule

### test/bilinear_lut_interpolator_unit_test.sv
`timescale 1ns / 100ps

module bilinear_lut_interpolator_unit_test;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 400;

  logic clk, rst;
  logic cfg_we, cfg_index;
  logic [bli_pkg::COUNT_BITS-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [bli_pkg::FUNC_BITS-1:0] func;
  logic [bli_pkg::SLOT_BITS-1:0] slot;
  logic [31:0] write_value, query_x, query_y;
  logic out_valid, out_ready;
  logic [31:0] result_value;
  logic segment_error;
  int fails, pending;
  int tx_idle_pct, rx_idle_pct;
  int cycles;
  bit long_hold_go;
  int grid_step;

  bilinear_lut_interpolator_unit dut (.*);

  bli_result_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (long_hold_go) begin
        out_ready <= 0;
        repeat (600) @(posedge clk);
        long_hold_go = 0;
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send(logic [1:0] f, logic [5:0] s, logic [31:0] wv,
                      logic [31:0] qx, logic [31:0] qy);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    func <= f;
    slot <= s;
    write_value <= wv;
    query_x <= qx;
    query_y <= qy;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_counts(logic [3:0] rc, logic [3:0] cc);
    cfg_we <= 1;
    cfg_index <= bli_pkg::CFG_ROW_COUNT;
    cfg_data <= rc;
    @(posedge clk);
    cfg_index <= bli_pkg::CFG_COL_COUNT;
    cfg_data <= cc;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] grid(int s);
    return 32'((s - 4) * grid_step);
  endfunction

  function automatic logic [31:0] pick_query();
    int k;
    k = $urandom_range(0, 99);
    if (k < 5) return 32'h7fffffff;
    if (k < 10) return 32'h80000000;
    if (k < 20) return $urandom;
    return 32'($signed($urandom_range(0, 12 * grid_step)) - 6 * grid_step);
  endfunction

  task automatic load_grid();
    for (int s = 0; s < 8; s++)
      send(bli_pkg::FUNC_ROW_WR, 6'(s), grid(s), $urandom, $urandom);
    for (int s = 0; s < 8; s++)
      send(bli_pkg::FUNC_COL_WR, 6'(s), grid(s) + 7, $urandom, $urandom);
  endtask

  task automatic random_item();
    int k, s;
    logic [31:0] v;
    k = $urandom_range(0, 99);
    if (k < 60) begin
      send(bli_pkg::FUNC_QUERY, 6'($urandom), $urandom, pick_query(), pick_query());
    end else if (k < 80) begin
      send(bli_pkg::FUNC_TAB_WR, 6'($urandom),
           ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 22))
           - (1 << 21)), $urandom, $urandom);
    end else begin
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 63) : $urandom_range(0, 7);
      v = ($urandom_range(0, 7) == 0) ? $urandom : grid(s) + $urandom_range(0, 3);
      send((k < 90) ? bli_pkg::FUNC_ROW_WR : bli_pkg::FUNC_COL_WR, 6'(s), v,
           $urandom, $urandom);
    end
  endtask

  initial begin
    logic [3:0] row_cfgs [8] = '{4'd1, 4'd0, 4'd1, 4'd8, 4'd8, 4'd2, 4'd15, 4'd3};
    logic [3:0] col_cfgs [8] = '{4'd1, 4'd15, 4'd8, 4'd1, 4'd8, 4'd2, 4'd0, 4'd5};
    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    func = 0;
    slot = 0;
    write_value = 0;
    query_x = 0;
    query_y = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold_go = 0;
    grid_step = 1 << 16;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    load_grid();
    for (int s = 0; s < 64; s++)
      send(bli_pkg::FUNC_TAB_WR, 6'(s), $urandom, $urandom, $urandom);
    send(bli_pkg::FUNC_QUERY, 6'd0, 32'd0, 32'd5, 32'd9);
    wait_idle();
    set_counts(4'd8, 4'd8);
    send(bli_pkg::FUNC_QUERY, 6'd63, 32'hffffffff, 32'h80000000, 32'h7fffffff);
    send(bli_pkg::FUNC_QUERY, 6'd0, 32'd0, 32'h7fffffff, 32'h80000000);
    send(bli_pkg::FUNC_QUERY, 6'd0, 32'd0, 32'h00012345, 32'hffff8000);
    send(bli_pkg::FUNC_QUERY, 6'd0, 32'd0, 32'hff000000, 32'h01000000);
    send(bli_pkg::FUNC_QUERY, 6'd0, 32'd0, grid(3), grid(0) + 7);
    send(bli_pkg::FUNC_TAB_WR, 6'd0, 32'h7fffffff, 32'd0, 32'd0);
    send(bli_pkg::FUNC_TAB_WR, 6'd8, 32'h80000000, 32'd0, 32'd0);
    send(bli_pkg::FUNC_QUERY, 6'd0, 32'd0, 32'h80000001, 32'h80000001);
    send(bli_pkg::FUNC_ROW_WR, 6'd40, 32'h12345678, 32'd0, 32'd0);
    send(bli_pkg::FUNC_ROW_WR, 6'd3, grid(2), 32'd0, 32'd0);
    send(bli_pkg::FUNC_QUERY, 6'd0, 32'd0, grid(2) + 1, 32'd0);
    send(bli_pkg::FUNC_COL_WR, 6'd5, grid(2), 32'd0, 32'd0);
    send(bli_pkg::FUNC_QUERY, 6'd0, 32'd0, grid(3) + 1, grid(3));
    send(bli_pkg::FUNC_QUERY, 6'd0, 32'd0, 32'd0, grid(4));

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph < 3) begin
        tx_idle_pct = 29;
        rx_idle_pct = 70;
      end else if (ph < 6) begin
        tx_idle_pct = 70;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_counts(row_cfgs[ph], col_cfgs[ph]);
      grid_step = (ph == 4) ? (1 << 26) : $urandom_range(1, 1 << 20);
      load_grid();
      for (int i = 0; i < 95; i++) begin
        if (ph == 4 && i == 10) long_hold_go = 1;
        random_item();
      end
    end

    wait_idle();
    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
